/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// check that a condition holds in the cycle after a trigger
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* rtl/rvdec_pkg.sv */
// ----------------------------------------------------------------------------
// rvdec_pkg
// Format codes, instruction ids, error codes and result type of the decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

    typedef enum logic [4:0] {
        F_UNK, F_CR, F_CI, F_CSS, F_CIW, F_CL, F_CS, F_CA, F_CB, F_CJ, F_OPCFG,
        F_OPIVV, F_OPFVV, F_OPMVV, F_OPIVI, F_OPIVX, F_OPFVF, F_OPMVX,
        F_R, F_R4, F_I, F_S, F_B, F_U, F_J
    } t_fmt;

    typedef enum logic [6:0] {
        ID_UNKNOWN,
        ID_C_ADDI4SPN, ID_C_FLD, ID_C_LW, ID_C_LD, ID_C_FSD, ID_C_SW, ID_C_SD,
        ID_C_NOP, ID_C_ADDI, ID_C_ADDIW, ID_C_LI, ID_C_ADDI16SP, ID_C_LUI,
        ID_C_SRLI, ID_C_SRAI, ID_C_ANDI, ID_C_SUB, ID_C_XOR, ID_C_OR, ID_C_AND,
        ID_C_J, ID_C_BEQZ, ID_C_BNEZ, ID_C_SLLI, ID_C_FLDSP, ID_C_LWSP, ID_C_LDSP,
        ID_C_JR, ID_C_MV, ID_C_EBREAK, ID_C_JALR, ID_C_ADD, ID_C_FSDSP, ID_C_SWSP,
        ID_C_SDSP,
        ID_LB, ID_LH, ID_LW, ID_LD, ID_LBU, ID_LHU, ID_LWU, ID_ADDI, ID_AUIPC,
        ID_OPIMM32, ID_FENCE, ID_SD, ID_LR, ID_ADD, ID_LUI, ID_SUBW, ID_FMADD,
        ID_FNMSUB, ID_FMV, ID_BNE, ID_JALR, ID_JAL, ID_CSRRS, ID_FPLOAD, ID_FPSTORE,
        ID_VSETVLI, ID_VSETIVLI, ID_VSETVL, ID_VADD, ID_VSUB, ID_VRSUB, ID_VRGATHER,
        ID_VSLIDEDOWN, ID_VMERGE, ID_VSLL, ID_VSMUL, ID_VREDSUM, ID_VMACC,
        ID_VMV_S_X, ID_VMV_X_S, ID_VPOPC, ID_VFIRST, ID_VMSBF, ID_VMSOF, ID_VMSIF,
        ID_VIOTA, ID_VID, ID_VFADD, ID_VFREDUSUM, ID_VFREDOSUM, ID_VFMV_S_F,
        ID_VFMV_F_S, ID_VFMV, ID_VMFNE, ID_VFMUL, ID_VFNMSUB, ID_VFMACC, ID_VFNMSAC
    } t_id;

    typedef enum logic [2:0] {
        E_NONE      = 3'd0,
        E_RESERVED  = 3'd1,
        E_UNDEF     = 3'd2,
        E_OPERANDS  = 3'd3,
        E_OPCODE    = 3'd4
    } t_err;

    localparam logic [6:0] OP_LOAD    = 7'h03;
    localparam logic [6:0] OP_FPLOAD  = 7'h07;
    localparam logic [6:0] OP_FENCE   = 7'h0F;
    localparam logic [6:0] OP_IMM     = 7'h13;
    localparam logic [6:0] OP_AUIPC   = 7'h17;
    localparam logic [6:0] OP_IMM32   = 7'h1B;
    localparam logic [6:0] OP_STORE   = 7'h23;
    localparam logic [6:0] OP_FPSTORE = 7'h27;
    localparam logic [6:0] OP_AMO     = 7'h2F;
    localparam logic [6:0] OP_OP      = 7'h33;
    localparam logic [6:0] OP_LUI     = 7'h37;
    localparam logic [6:0] OP_OP32    = 7'h3B;
    localparam logic [6:0] OP_MADD    = 7'h43;
    localparam logic [6:0] OP_NMSUB   = 7'h4B;
    localparam logic [6:0] OP_FP      = 7'h53;
    localparam logic [6:0] OP_VECTOR  = 7'h57;
    localparam logic [6:0] OP_BRANCH  = 7'h63;
    localparam logic [6:0] OP_JALR    = 7'h67;
    localparam logic [6:0] OP_JAL     = 7'h6F;
    localparam logic [6:0] OP_SYSTEM  = 7'h73;

    typedef struct packed {
        logic               is_compressed;
        t_id                inst_id;
        t_fmt               fmt_code;
        logic        [19:0] slice_a;
        logic        [7:0]  slice_b;
        logic        [7:0]  slice_c;
        logic        [4:0]  slice_d;
        logic               slice_e;
        logic signed [11:0] jump_offset;
        logic               illegal;
        t_err               error_code;
    } t_dec;

endpackage

/* rtl/rvdec_logic.sv */
// ----------------------------------------------------------------------------
// rvdec_logic
// Combinational decode of one instruction word into id, format, slices and error code.
// ----------------------------------------------------------------------------
module rvdec_logic
    import rvdec_pkg::*;
(
    input  logic [31:0] i_word,
    output t_dec        o_dec
);

    t_id  id;
    t_fmt fmt;
    t_err err;
    logic [19:0] sa;
    logic [7:0]  sb;
    logic [7:0]  sc;
    logic [4:0]  sd;
    logic        se;
    logic [11:0] joff;
    logic        comp;
    logic [2:0]  cf3;
    logic [4:0]  crd;
    logic [4:0]  crs2;
    logic [2:0]  vf3;
    logic [5:0]  vf6;
    logic [4:0]  vs2;
    logic [4:0]  vs1;

    assign comp = (i_word[1:0] != 2'b11);
    assign cf3  = i_word[15:13];
    assign crd  = i_word[11:7];
    assign crs2 = i_word[6:2];
    assign vf3  = i_word[14:12];
    assign vf6  = i_word[31:26];
    assign vs2  = i_word[24:20];
    assign vs1  = i_word[19:15];

    always_comb begin
        id   = ID_UNKNOWN;
        fmt  = F_UNK;
        err  = E_NONE;
        sa   = '0;
        sb   = '0;
        sc   = '0;
        sd   = '0;
        se   = 1'b0;
        joff = '0;
        if (comp) begin
            unique case (i_word[1:0])
                2'd0: begin
                    unique case (cf3)
                        3'd0: begin id = ID_C_ADDI4SPN; fmt = F_CIW; end
                        3'd1: begin id = ID_C_FLD; fmt = F_CL; end
                        3'd2: begin id = ID_C_LW;  fmt = F_CL; end
                        3'd3: begin id = ID_C_LD;  fmt = F_CL; end
                        3'd4: err = E_RESERVED;
                        3'd5: begin id = ID_C_FSD; fmt = F_CS; end
                        3'd6: begin id = ID_C_SW;  fmt = F_CS; end
                        default: begin id = ID_C_SD; fmt = F_CS; end
                    endcase
                end
                2'd1: begin
                    unique case (cf3)
                        3'd0: begin
                            id  = (crd != 5'd0) ? ID_C_ADDI : ID_C_NOP;
                            fmt = F_CI;
                        end
                        3'd1: begin id = ID_C_ADDIW; fmt = F_CI; end
                        3'd2: begin id = ID_C_LI; fmt = F_CI; end
                        3'd3: begin
                            if (crd == 5'd2) begin
                                id = ID_C_ADDI16SP; fmt = F_CI;
                            end else if (crd != 5'd0) begin
                                id = ID_C_LUI; fmt = F_CI;
                            end else begin
                                err = E_UNDEF;
                            end
                        end
                        3'd4: begin
                            unique case (i_word[11:10])
                                2'd0: begin id = ID_C_SRLI; fmt = F_CB; end
                                2'd1: begin id = ID_C_SRAI; fmt = F_CB; end
                                2'd2: begin id = ID_C_ANDI; fmt = F_CB; end
                                default: begin
                                    id  = t_id'(ID_C_SUB + {5'd0, i_word[6:5]});
                                    fmt = F_CA;
                                end
                            endcase
                        end
                        3'd5: begin id = ID_C_J; fmt = F_CJ; end
                        3'd6: begin id = ID_C_BEQZ; fmt = F_CB; end
                        default: begin id = ID_C_BNEZ; fmt = F_CB; end
                    endcase
                end
                default: begin
                    unique case (cf3)
                        3'd0: begin id = ID_C_SLLI;  fmt = F_CI; end
                        3'd1: begin id = ID_C_FLDSP; fmt = F_CI; end
                        3'd2: begin id = ID_C_LWSP;  fmt = F_CI; end
                        3'd3: begin id = ID_C_LDSP;  fmt = F_CI; end
                        3'd4: begin
                            if (i_word[12]) begin
                                if (crd == 5'd0 && crs2 == 5'd0) begin
                                    id = ID_C_EBREAK; fmt = F_CR;
                                end else if (crd == 5'd0) begin
                                    err = E_OPERANDS;
                                end else begin
                                    id  = (crs2 != 5'd0) ? ID_C_ADD : ID_C_JALR;
                                    fmt = F_CR;
                                end
                            end else begin
                                id  = (crs2 != 5'd0) ? ID_C_MV : ID_C_JR;
                                fmt = F_CR;
                            end
                        end
                        3'd5: begin id = ID_C_FSDSP; fmt = F_CSS; end
                        3'd6: begin id = ID_C_SWSP;  fmt = F_CSS; end
                        default: begin id = ID_C_SDSP; fmt = F_CSS; end
                    endcase
                end
            endcase
            unique case (fmt)
                F_CR: begin sa = {15'd0, i_word[11:7]}; sb = {3'd0, i_word[6:2]}; end
                F_CI: begin
                    sa = {19'd0, i_word[12]};
                    sb = {3'd0, i_word[11:7]};
                    sc = {3'd0, i_word[6:2]};
                end
                F_CSS: begin sa = {14'd0, i_word[12:7]}; sb = {3'd0, i_word[6:2]}; end
                F_CIW: begin sa = {12'd0, i_word[12:5]}; sb = {5'd0, i_word[4:2]}; end
                F_CL, F_CS: begin
                    sa = {17'd0, i_word[12:10]};
                    sb = {5'd0, i_word[9:7]};
                    sc = {6'd0, i_word[6:5]};
                    sd = {2'd0, i_word[4:2]};
                end
                F_CA: begin sa = {17'd0, i_word[9:7]}; sb = {5'd0, i_word[4:2]}; end
                F_CB: begin
                    sa = {17'd0, i_word[12:10]};
                    sb = {5'd0, i_word[9:7]};
                    sc = {3'd0, i_word[6:2]};
                end
                F_CJ: begin
                    joff = {i_word[12], i_word[8], i_word[10:9], i_word[6], i_word[7],
                            i_word[2], i_word[11], i_word[5:3], 1'b0};
                    sa   = {8'd0, joff};
                end
                default: ;
            endcase
        end else begin
            unique case (i_word[6:0])
                OP_FPLOAD:  id = ID_FPLOAD;
                OP_FPSTORE: id = ID_FPSTORE;
                OP_SYSTEM:  id = ID_CSRRS;
                OP_VECTOR: begin
                    if (vf3 == 3'd7) begin
                        fmt = F_OPCFG;
                        unique case (i_word[31:30])
                            2'd2:    id = ID_VSETVL;
                            2'd3:    id = ID_VSETIVLI;
                            default: id = ID_VSETVLI;
                        endcase
                    end else begin
                        fmt = t_fmt'(F_OPIVV + {2'd0, vf3});
                        sa  = {15'd0, vs2};
                        sb  = {3'd0, vs1};
                        sc  = {3'd0, i_word[11:7]};
                        if (vf3 == 3'd0 || vf3 == 3'd3 || vf3 == 3'd4) begin
                            unique case (vf6)
                                6'h00: id = ID_VADD;
                                6'h02: id = ID_VSUB;
                                6'h03: id = ID_VRSUB;
                                6'h0C: id = ID_VRGATHER;
                                6'h0F: id = ID_VSLIDEDOWN;
                                6'h17: id = ID_VMERGE;
                                6'h25: id = ID_VSLL;
                                6'h27: id = ID_VSMUL;
                                default: err = E_UNDEF;
                            endcase
                        end else if (vf3 == 3'd2 || vf3 == 3'd6) begin
                            unique case (vf6)
                                6'h00: id = ID_VREDSUM;
                                6'h2D: id = ID_VMACC;
                                6'h10: begin
                                    if (vf3 == 3'd6) begin
                                        if (vs2 != 5'd0) err = E_UNDEF;
                                        else id = ID_VMV_S_X;
                                    end else if (vs1 == 5'd0) id = ID_VMV_X_S;
                                    else if (vs1 == 5'h10) id = ID_VPOPC;
                                    else if (vs1 == 5'h11) id = ID_VFIRST;
                                    else err = E_UNDEF;
                                end
                                6'h14: begin
                                    if (vf3 == 3'd2) begin
                                        if (vs1 == 5'd1) id = ID_VMSBF;
                                        else if (vs1 == 5'd2) id = ID_VMSOF;
                                        else if (vs1 == 5'd3) id = ID_VMSIF;
                                        else if (vs1 == 5'h10) id = ID_VIOTA;
                                        else if (vs1 == 5'h11) id = ID_VID;
                                    end
                                end
                                default: err = E_UNDEF;
                            endcase
                        end else begin
                            unique case (vf6)
                                6'h00: id = ID_VFADD;
                                6'h01: id = ID_VFREDUSUM;
                                6'h03: id = ID_VFREDOSUM;
                                6'h10: begin
                                    if (vs2 == 5'd0) id = ID_VFMV_S_F;
                                    else if (vs1 == 5'd0) id = ID_VFMV_F_S;
                                    else err = E_UNDEF;
                                end
                                6'h17: id = ID_VFMV;
                                6'h1C: id = ID_VMFNE;
                                6'h24: id = ID_VFMUL;
                                6'h2B: id = ID_VFNMSUB;
                                6'h2C: id = ID_VFMACC;
                                6'h2F: id = ID_VFNMSAC;
                                default: err = E_UNDEF;
                            endcase
                        end
                    end
                end
                OP_LOAD: begin
                    fmt = F_I;
                    unique case (vf3)
                        3'd0: id = ID_LB;
                        3'd1: id = ID_LH;
                        3'd2: id = ID_LW;
                        3'd3: id = ID_LD;
                        3'd4: id = ID_LBU;
                        3'd5: id = ID_LHU;
                        3'd6: id = ID_LWU;
                        default: err = E_OPCODE;
                    endcase
                end
                OP_IMM:    begin id = ID_ADDI;    fmt = F_I;  end
                OP_AUIPC:  begin id = ID_AUIPC;   fmt = F_U;  end
                OP_IMM32:  begin id = ID_OPIMM32; fmt = F_I;  end
                OP_FENCE:  begin id = ID_FENCE;   fmt = F_I;  end
                OP_STORE:  begin id = ID_SD;      fmt = F_S;  end
                OP_AMO:    begin id = ID_LR;      fmt = F_R;  end
                OP_OP:     begin id = ID_ADD;     fmt = F_R;  end
                OP_LUI:    begin id = ID_LUI;     fmt = F_U;  end
                OP_OP32:   begin id = ID_SUBW;    fmt = F_R;  end
                OP_MADD:   begin id = ID_FMADD;   fmt = F_R4; end
                OP_NMSUB:  begin id = ID_FNMSUB;  fmt = F_R4; end
                OP_FP:     begin id = ID_FMV;     fmt = F_R;  end
                OP_BRANCH: begin id = ID_BNE;     fmt = F_B;  end
                OP_JALR:   begin id = ID_JALR;    fmt = F_I;  end
                OP_JAL:    begin id = ID_JAL;     fmt = F_J;  end
                default: err = E_OPCODE;
            endcase
            unique case (fmt)
                F_R, F_S: begin
                    sa = {13'd0, i_word[31:25]};
                    sb = {3'd0, i_word[24:20]};
                    sc = {3'd0, i_word[19:15]};
                    sd = i_word[11:7];
                end
                F_R4: begin
                    sa = {15'd0, i_word[31:27]};
                    sb = {3'd0, i_word[24:20]};
                    sc = {3'd0, i_word[19:15]};
                    sd = i_word[11:7];
                end
                F_I: begin
                    sa = {8'd0, i_word[31:20]};
                    sb = {3'd0, i_word[19:15]};
                    sc = {3'd0, i_word[11:7]};
                end
                F_B: begin
                    sa = {14'd0, i_word[30:25]};
                    sb = {3'd0, i_word[24:20]};
                    sc = {3'd0, i_word[19:15]};
                    sd = {1'b0, i_word[11:8]};
                    se = i_word[7];
                end
                F_U: begin sa = i_word[31:12]; sb = {3'd0, i_word[11:7]}; end
                F_J: begin
                    sa = {10'd0, i_word[30:21]};
                    sb = {7'd0, i_word[20]};
                    sc = i_word[19:12];
                    sd = i_word[11:7];
                end
                default: ;
            endcase
        end

        o_dec.is_compressed = comp;
        o_dec.illegal       = (err != E_NONE);
        o_dec.error_code    = err;
        if (err != E_NONE) begin
            o_dec.inst_id     = ID_UNKNOWN;
            o_dec.fmt_code    = F_UNK;
            o_dec.slice_a     = '0;
            o_dec.slice_b     = '0;
            o_dec.slice_c     = '0;
            o_dec.slice_d     = '0;
            o_dec.slice_e     = 1'b0;
            o_dec.jump_offset = '0;
        end else begin
            o_dec.inst_id     = id;
            o_dec.fmt_code    = fmt;
            o_dec.slice_a     = sa;
            o_dec.slice_b     = sb;
            o_dec.slice_c     = sc;
            o_dec.slice_d     = sd;
            o_dec.slice_e     = se;
            o_dec.jump_offset = joff;
        end
    end

endmodule

/* rtl/riscv_subset_instruction_decoder_unit.sv */
// Decodes one instruction word per cycle while results are taken. An accepted
// word is held in an input register, decoded by one level of combinational logic
// and captured in a result register; a result is offered once its word has passed
// through both registers, and a new word can be taken every cycle, with a skid-free
// stall that holds both stages when the result is not taken.
// ----------------------------------------------------------------------------
// riscv_subset_instruction_decoder_unit
// Top level: input register, decode logic and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module riscv_subset_instruction_decoder_unit
    import rvdec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_instr_word,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_is_compressed,
    output logic [6:0]         o_inst_id,
    output logic [4:0]         o_fmt_code,
    output logic [19:0]        o_slice_a,
    output logic [7:0]         o_slice_b,
    output logic [7:0]         o_slice_c,
    output logic [4:0]         o_slice_d,
    output logic               o_slice_e,
    output logic signed [11:0] o_jump_offset,
    output logic               o_illegal,
    output logic [2:0]         o_error_code
);

    logic        r_in_vld;
    logic [31:0] r_word;
    logic        r_out_vld;
    t_dec        r_dec;
    t_dec        n_dec;
    logic        out_adv;
    logic        in_adv;

    rvdec_logic u_logic (
        .i_word (r_word),
        .o_dec  (n_dec)
    );

    assign out_adv = !r_out_vld || i_ready;
    assign in_adv  = !r_in_vld || out_adv;
    assign o_ready = in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_adv) r_in_vld <= i_valid;
            if (out_adv) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_valid) r_word <= i_instr_word;
        if (out_adv && r_in_vld) r_dec <= n_dec;
    end

    assign o_valid         = r_out_vld;
    assign o_is_compressed = r_dec.is_compressed;
    assign o_inst_id       = r_dec.inst_id;
    assign o_fmt_code      = r_dec.fmt_code;
    assign o_slice_a       = r_dec.slice_a;
    assign o_slice_b       = r_dec.slice_b;
    assign o_slice_c       = r_dec.slice_c;
    assign o_slice_d       = r_dec.slice_d;
    assign o_slice_e       = r_dec.slice_e;
    assign o_jump_offset   = r_dec.jump_offset;
    assign o_illegal       = r_dec.illegal;
    assign o_error_code    = r_dec.error_code;

    `ASSERT_IMPL(a_illegal_zero, i_clk, i_rst_n, o_valid && o_illegal,
        o_inst_id == 7'd0 && o_fmt_code == 5'd0 && o_slice_a == 20'd0)
    `ASSERT_IMPL(a_err_flag, i_clk, i_rst_n, o_valid, o_illegal == (o_error_code != 3'd0))
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(r_dec))
    `ASSERT_NEXT(a_fill, i_clk, i_rst_n, r_in_vld && out_adv, o_valid)

endmodule
